// ===== design/lzssd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared types and constants of the LZSS byte stream decoder.
// ----------------------------------------------------------------------------
package lzssd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 6;
	localparam int DIST_W = 10;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [DIST_W-1:0] dist_t;

	// Window contents after reset.
	localparam byte_t FILL_RESET = 8'h11;

	// Flag bits governed by one flag byte; counter restarts a group here.
	localparam logic [3:0] FLAG_GROUP   = 4'd8;
	localparam logic [3:0] FLAG_CNT_RST = 4'd7;

	// Token phase codes.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_TOKEN = 2'd1;
	localparam logic [1:0] PH_CODE  = 2'd2;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;

	// Output queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 2);

	typedef struct packed {
		byte_t data;
		logic  last;
	} out_item_t;

endpackage

// ===== design/lzss_byte_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// lzss_byte_stream_decoder_core
// LZSS decoder: flag bytes, literals and 10-bit distance / 6-bit length codes
// over a circular history window held in a single-port-per-direction RAM.
// ----------------------------------------------------------------------------
// Sequence: a flag byte, a literal or a first code byte starts no sequencer run.
// A second code byte of length L holds in_stall through these steps:
// set up the read pointer, read L bytes from the window RAM (one byte out per
// cycle while the output queue has room), let the last read land in the copy
// buffer, read the L bytes back from the copy buffer, and finish the last
// write into the window RAM. A zero length code starts no copy.
// After reset and after every write of cfg_wr_data, the window RAM is swept
// once, one entry per cycle; in_stall stays high during that sweep.
module lzss_byte_stream_decoder_core
	import lzssd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last
);

	localparam int AW        = $clog2(WINDOW_DEPTH);
	localparam int MOD_STEPS = $clog2((2**DIST_W + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
	localparam int CMP_W     = DIST_W + MOD_STEPS + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X   = (AW+1)'(WINDOW_DEPTH);

	// distance modulo the window depth by restoring compare and subtract
	function automatic logic [AW-1:0] dist_mod(input dist_t d);
		logic [CMP_W-1:0] r;
		r = CMP_W'(d);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (r >= (CMP_W'(WINDOW_DEPTH) << k)) begin
				r = r - (CMP_W'(WINDOW_DEPTH) << k);
			end
		end
		return r[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
		return (a == LAST_ADDR) ? '0 : a + AW'(1);
	endfunction

	// memories
	byte_t window_mem [WINDOW_DEPTH];
	byte_t copy_mem   [2**LEN_W - 1];

	// control state
	logic [2:0]    state_q;
	logic [1:0]    phase_q;
	logic [7:0]    flags_q;
	logic [3:0]    flag_cnt_q;
	byte_t         held_q;
	byte_t         fill_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] dist_red_q;
	len_t          len_q;
	len_t          cnt_q;

	// pipeline
	logic          rd_valid_s1;
	logic          rd_last_s1;
	len_t          rd_idx_s1;
	byte_t         win_rdata_s1;
	logic          wb_valid_s1;
	byte_t         cb_rdata_s1;

	// output queue
	out_item_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   head_q;
	logic [FIFO_AW-1:0]   tail_q;
	logic [FIFO_CW-1:0]   count_q;

	logic          accept;
	logic          tok;
	logic          tok_flag;
	logic          code2;
	logic          load_flags;
	logic [7:0]    flags_sh;
	logic [3:0]    cnt_inc;
	logic          lit_accept;
	logic          rd_issue;
	logic          cb_issue;
	logic          push;
	logic          pop;
	out_item_t     push_item;
	logic          win_we;
	logic [AW-1:0] win_wa;
	byte_t         win_wd;
	len_t          code_len;

	assign in_stall = !(state_q == ST_IDLE && !rd_valid_s1 && !wb_valid_s1
		&& count_q != FIFO_CW'(FIFO_DEPTH));
	assign accept   = in_valid && !in_stall;
	assign code_len = held_q[7:2];

	// token decode
	always_comb begin
		tok        = 1'b0;
		tok_flag   = 1'b0;
		code2      = 1'b0;
		load_flags = 1'b0;
		flags_sh   = {flags_q[6:0], 1'b0};
		cnt_inc    = flag_cnt_q + 4'd1;
		case (phase_q)
			PH_TOKEN: begin
				tok      = 1'b1;
				tok_flag = flags_q[7];
			end
			PH_CODE: begin
				code2 = 1'b1;
			end
			default: begin
				if (cnt_inc >= FLAG_GROUP) begin
					load_flags = 1'b1;
				end else begin
					tok      = 1'b1;
					tok_flag = flags_sh[7];
				end
			end
		endcase
	end

	assign lit_accept = accept && tok && !tok_flag;

	assign rd_issue = (state_q == ST_READ)
		&& (count_q + FIFO_CW'(rd_valid_s1) < FIFO_CW'(FIFO_DEPTH));
	assign cb_issue = (state_q == ST_WRITE) && !rd_valid_s1;

	// window write port: the sweep wins over a copy write-back; a literal writes only when neither is active
	always_comb begin
		win_we = 1'b0;
		win_wa = wp_q;
		win_wd = in_byte;
		if (state_q == ST_CLEAR) begin
			win_we = 1'b1;
			win_wa = clr_q;
			win_wd = fill_q;
		end else if (wb_valid_s1) begin
			win_we = 1'b1;
			win_wd = cb_rdata_s1;
		end else if (lit_accept) begin
			win_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			window_mem[win_wa] <= win_wd;
		end
		if (rd_issue) begin
			win_rdata_s1 <= window_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			copy_mem[rd_idx_s1] <= win_rdata_s1;
		end
		if (cb_issue) begin
			cb_rdata_s1 <= copy_mem[cnt_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= PH_IDLE;
			flags_q     <= '0;
			flag_cnt_q  <= FLAG_CNT_RST;
			held_q      <= '0;
			fill_q      <= FILL_RESET;
			wp_q        <= '0;
			rd_ptr_q    <= '0;
			clr_q       <= '0;
			dist_red_q  <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			rd_idx_s1   <= '0;
			wb_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_issue;
			wb_valid_s1 <= cb_issue;
			if (wb_valid_s1) begin
				wp_q <= addr_inc(wp_q);
			end

			if (accept) begin
				if (phase_q != PH_TOKEN && phase_q != PH_CODE) begin
					flags_q    <= load_flags ? in_byte : flags_sh;
					flag_cnt_q <= load_flags ? 4'd0 : cnt_inc;
				end
				if (load_flags) begin
					phase_q <= PH_TOKEN;
				end else if (tok && tok_flag) begin
					held_q  <= in_byte;
					phase_q <= PH_CODE;
				end else begin
					phase_q <= PH_IDLE;
				end
				if (lit_accept) begin
					wp_q <= addr_inc(wp_q);
				end
				if (code2 && code_len != '0) begin
					dist_red_q <= dist_mod({held_q[1:0], in_byte});
					len_q      <= code_len;
					state_q    <= ST_SETUP;
				end
			end

			case (state_q)
				ST_SETUP: begin
					if (wp_q >= dist_red_q) begin
						rd_ptr_q <= wp_q - dist_red_q;
					end else begin
						rd_ptr_q <= AW'(DEPTH_X + (AW+1)'(wp_q) - (AW+1)'(dist_red_q));
					end
					cnt_q   <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (rd_issue) begin
						rd_ptr_q   <= addr_inc(rd_ptr_q);
						rd_idx_s1  <= cnt_q;
						rd_last_s1 <= (cnt_q == len_q - len_t'(1));
						if (cnt_q == len_q - len_t'(1)) begin
							cnt_q   <= '0;
							state_q <= ST_WRITE;
						end else begin
							cnt_q <= cnt_q + len_t'(1);
						end
					end
				end
				ST_WRITE: begin
					if (cb_issue) begin
						if (cnt_q == len_q - len_t'(1)) begin
							state_q <= ST_IDLE;
						end
						cnt_q <= cnt_q + len_t'(1);
					end
				end
				ST_CLEAR: begin
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
					clr_q <= addr_inc(clr_q);
				end
				default: begin
				end
			endcase

			// new fill value: restart the sweep
			if (cfg_wr_en) begin
				fill_q  <= cfg_wr_data;
				clr_q   <= '0;
				state_q <= ST_CLEAR;
			end
		end
	end

	// output queue
	assign push      = rd_valid_s1 || lit_accept;
	assign pop       = out_valid && !out_stall;
	assign push_item = rd_valid_s1 ? out_item_t'{data: win_rdata_s1, last: rd_last_s1}
		: out_item_t'{data: in_byte, last: 1'b1};

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[tail_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + FIFO_AW'(1);
			end
			if (pop) begin
				head_q <= head_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	assign out_valid = (count_q != '0);
	assign out_byte  = fifo_q[head_q].data;
	assign run_last  = fifo_q[head_q].last;

endmodule

// ===== test/lzss_byte_stream_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_byte_stream_decoder_checker
// Watches the compressed and decoded byte channels of the LZSS decoder. It
// decodes every accepted compressed byte on its own copy of the history
// window and compares each decoded byte and its run_last flag in order.
// ----------------------------------------------------------------------------
module lzss_byte_stream_decoder_checker
	import lzssd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 1023
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	output int         fail_count,
	output int         pending
);

	localparam int REPORT_MAX = 10;

	byte_t      history [WINDOW_DEPTH];
	byte_t      copy_snap [64];
	int         wr_pos;
	byte_t      flags;
	logic [3:0] flags_used;
	logic [1:0] phase;
	byte_t      held_code;
	out_item_t  decoded_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic refill_history(input byte_t v);
		for (int i = 0; i < WINDOW_DEPTH; i++)
			history[i] = v;
	endtask

	task automatic push_decoded(input byte_t v, input logic last);
		out_item_t item;
		item.data = v;
		item.last = last;
		decoded_q.push_back(item);
	endtask

	task automatic start_token(input byte_t b);
		if (!flags[7]) begin
			history[wr_pos] = b;
			wr_pos = (wr_pos + 1) % WINDOW_DEPTH;
			push_decoded(b, 1'b1);
			phase = PH_IDLE;
		end else begin
			held_code = b;
			phase = PH_CODE;
		end
	endtask

	// All reads see the window before the copy; write back afterwards.
	task automatic expand_copy(input byte_t dist_lo);
		len_t  run_len;
		dist_t code_dist;
		int    base;
		run_len   = held_code[7:2];
		code_dist = {held_code[1:0], dist_lo};
		base      = wr_pos + WINDOW_DEPTH - (int'(code_dist) % WINDOW_DEPTH);
		phase     = PH_IDLE;
		for (int i = 0; i < int'(run_len); i++) begin
			copy_snap[i] = history[(base + i) % WINDOW_DEPTH];
			push_decoded(copy_snap[i], (i + 1) == int'(run_len));
		end
		for (int i = 0; i < int'(run_len); i++)
			history[(wr_pos + i) % WINDOW_DEPTH] = copy_snap[i];
		wr_pos = (wr_pos + int'(run_len)) % WINDOW_DEPTH;
	endtask

	task automatic decode_byte(input byte_t b);
		case (phase)
			PH_TOKEN: start_token(b);
			PH_CODE:  expand_copy(b);
			default: begin
				flags      = flags << 1;
				flags_used = flags_used + 4'd1;
				if (flags_used >= FLAG_GROUP) begin
					flags      = b;
					flags_used = '0;
					phase      = PH_TOKEN;
				end else begin
					start_token(b);
				end
			end
		endcase
	endtask

	task automatic check_decoded();
		out_item_t want;
		if (decoded_q.size() == 0) begin
			if (fail_count < REPORT_MAX)
				$display("%0t: unexpected decoded byte %02h run_last %0b",
					$time, out_byte, run_last);
			fail_count++;
		end else begin
			want = decoded_q.pop_front();
			if (want.data !== out_byte || want.last !== run_last) begin
				if (fail_count < REPORT_MAX)
					$display("%0t: out_byte exp %02h got %02h, run_last exp %0b got %0b",
						$time, want.data, out_byte, want.last, run_last);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refill_history(FILL_RESET);
			wr_pos     = 0;
			flags      = '0;
			flags_used = FLAG_CNT_RST;
			phase      = PH_IDLE;
			held_code  = '0;
			decoded_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_wr_en)
				refill_history(cfg_wr_data);
			// predict first so a same-edge result still finds its expectation
			if (in_valid && !in_stall)
				decode_byte(in_byte);
			if (out_valid && !out_stall)
				check_decoded();
			pending = decoded_q.size();
		end
	end

endmodule

// ===== test/tb_lzss_byte_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzss_byte_stream_decoder_core
// Feeds compressed streams to the LZSS decoder: a directed opening over
// literal extremes, zero and full lengths and distance corner values, then
// random flag groups, noise and cut-off groups under several fill values.
// The checker beside the block predicts and compares every decoded byte.
// ----------------------------------------------------------------------------
module tb_lzss_byte_stream_decoder_core;
	import lzssd_pkg::*;

	localparam int WINDOW_DEPTH  = 1023;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 160;
	localparam int PHASE_BYTES   = 60;
	// Worst case: every code 63 bytes long, each byte behind the longest stall,
	// plus a window sweep per fill write; taken several times over.
	localparam int CYCLE_LIMIT   = 3_000_000;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte     = 8'h00;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	int fail_count;
	int pending;
	int cycles      = 0;
	int bytes_sent  = 0;
	int stall_left  = 0;
	logic idling    = 1'b1;

	// Parse position of the stream sent so far.
	byte_t grp_flags   = '0;
	int    tokens_left = 0;
	logic  mid_code    = 1'b0;

	always #10 clk = ~clk;

	lzss_byte_stream_decoder_core #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

	lzss_byte_stream_decoder_checker #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL lzss_byte_stream_decoder_core");
			$finish;
		end
	end

	// Output back-pressure: random stall bursts between open runs, only while idling is set.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (idling && $urandom_range(0, 2) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 14);
		end else begin
			out_stall  <= 1'b0;
			stall_left <= $urandom_range(0, 39);
		end
	end

	task automatic send_byte(input byte_t b);
		@(negedge clk);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		if (mid_code) begin
			mid_code = 1'b0;
			tokens_left--;
		end else if (tokens_left == 0) begin
			grp_flags   = b;
			tokens_left = 8;
		end else begin
			if (grp_flags[7])
				mid_code = 1'b1;
			else
				tokens_left--;
			grp_flags = grp_flags << 1;
		end
	endtask

	task automatic send_code(input len_t run_len, input dist_t back_dist);
		send_byte({run_len, back_dist[9:8]});
		send_byte(back_dist[7:0]);
	endtask

	task automatic send_token();
		len_t  run_len;
		dist_t back_dist;
		if (!grp_flags[7]) begin
			send_byte(byte_t'($urandom_range(0, 255)));
		end else begin
			// mostly short runs from recent history; sometimes anything goes
			if ($urandom_range(0, 4) == 0)
				run_len = len_t'($urandom_range(0, 63));
			else
				run_len = len_t'($urandom_range(0, 10));
			case ($urandom_range(0, 5))
				0:       back_dist = dist_t'($urandom_range(0, 1023));
				1:       back_dist = dist_t'($urandom_range(1015, 1023));
				2:       back_dist = dist_t'($urandom_range(0, 3));
				default: back_dist = dist_t'($urandom_range(1, 48));
			endcase
			send_code(run_len, back_dist);
		end
	endtask

	// Finish whatever group is open, then send one whole group.
	task automatic send_group();
		if (mid_code)
			send_byte(byte_t'($urandom_range(0, 255)));
		while (tokens_left > 0)
			send_token();
		send_byte(byte_t'($urandom_range(0, 255)));
		while (tokens_left > 0)
			send_token();
	endtask

	task automatic random_phase(input int count);
		int target;
		int pick;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_group();
			end else if (pick < 9) begin
				repeat ($urandom_range(1, 4))
					send_byte(byte_t'($urandom_range(0, 255)));
			end else begin
				// cut a group short
				repeat ($urandom_range(1, 6)) begin
					if (!mid_code && tokens_left > 0)
						send_token();
					else
						send_byte(byte_t'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// let the copy write-back finish
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_fill(input byte_t v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// two literals at the byte extremes, then six codes
		send_byte(8'b0011_1111);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_code(6'd0, 10'd5);
		send_code(6'd63, 10'd1);
		send_code(6'd1, 10'd0);
		send_code(6'd5, 10'd1023);
		send_code(6'd3, 10'd1022);
		send_code(6'd2, 10'd2);
		// long copy from deep history, then a group left open
		send_byte(8'h80);
		send_code(6'd63, 10'd700);
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_byte(byte_t'($urandom_range(0, 255)));

		wait_idle();
		write_fill(8'h00);
		random_phase(PHASE_BYTES);

		wait_idle();
		write_fill(8'hFF);
		random_phase(PHASE_BYTES);

		wait_idle();
		write_fill(byte_t'($urandom_range(1, 254)));
		idling = 1'b0;
		random_phase(PHASE_BYTES);

		// end on a lone first code byte
		send_group();
		send_byte(8'hC0);
		send_byte(8'h24);

		wait_idle();
		if (fail_count == 0)
			$display("PASS lzss_byte_stream_decoder_core");
		else
			$display("FAIL lzss_byte_stream_decoder_core");
		$finish;
	end

endmodule
